### sv/date_difference_in_days_unit_defines.svh
// Assertion macros for the date difference unit.
`ifndef DATE_DIFFERENCE_IN_DAYS_UNIT_DEFINES_SVH
`define DATE_DIFFERENCE_IN_DAYS_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define DD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define DD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/dd_pkg.sv
`default_nettype none

package dd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;
  // serial day number, large enough for every 14-bit year
  localparam int DNUM_W  = 23;
  localparam int YDAY_W  = 9;
  localparam int QUOT_W  = 8;   // year / 100 for a 14-bit year
  localparam int REM_W   = 7;   // year % 100

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact below 2**14
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  localparam logic [QUOT_W-1:0]  CENTURY       = 8'd100;
  localparam logic [DNUM_W-1:0]  DAYS_PER_YEAR = 23'd365;
  localparam logic [MONTH_W-1:0] FEBRUARY      = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER      = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic               include_end;
  } dd_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic               date_error;
  } dd_out_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = '0;
    endcase
    return len;
  endfunction

  // days in the year before the first of month m, common year
  function automatic logic [YDAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [YDAY_W-1:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### sv/dd_stream_if.sv
`default_nettype none

// Date pair channel.
interface dd_in_if;
  import dd_pkg::*;
  logic   valid;
  logic   ready;
  dd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Day count channel.
interface dd_out_if;
  import dd_pkg::*;
  logic    valid;
  logic    ready;
  dd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/date_difference_in_days_unit.sv
// Channel | Dir | Beat contents
// --------+-----+--------------------------------------------------------
// dates   | in  | start/end year, month, day and include_end
// days    | out | day_count (saturating) and date_error
//
// Four register stages; a beat may enter every cycle unless all are stalled.
// The per-stage valid/ready chain lets a stage fill whenever it is empty or
// the stage after it moves, so bubbles are squeezed out during a stall.
// The output register holds its beat until days.ready; nothing is lost or
// repeated. rst (synchronous) clears every valid bit; payload is not reset.
`default_nettype none
`include "date_difference_in_days_unit_defines.svh"

module date_difference_in_days_unit #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  wire logic clk,
  input  wire logic rst,
  dd_in_if.sink     dates,
  dd_out_if.source  days
);
  import dd_pkg::*;

  localparam int CMP_W = 17;
  localparam logic [CMP_W-1:0] MaxYear = CMP_W'(MAX_YEAR);
  localparam int PROD_W = YEAR_W + RECIP_W;

  // Lane 0 is the start date, lane 1 the end date.
  typedef struct packed {
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [QUOT_W-1:0]  q;     // y / 100
  } s1_lane_t;

  typedef struct packed {
    logic [YEAR_W-1:0] p;      // y - 1
    logic [QUOT_W-1:0] pq;     // (y - 1) / 100
    logic [YDAY_W-1:0] yday;   // day of the year, from 0
    logic              ok;
  } s2_lane_t;

  // ---------------------------------------------------------------- handshake
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !s4_valid || days.ready;
  assign rdy3 = !s3_valid || rdy4;
  assign rdy2 = !s2_valid || rdy3;
  assign rdy1 = !s1_valid || rdy2;

  assign dates.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid <= dates.valid;
      if (rdy2) s2_valid <= s1_valid;
      if (rdy3) s3_valid <= s2_valid;
      if (rdy4) s4_valid <= s3_valid;
    end
  end

  // ------------------------------------------- stage 1: century by reciprocal
  s1_lane_t         s1_lane [2];
  s1_lane_t         s1_lane_next [2];
  logic             s1_inc;
  logic [PROD_W-1:0] s1_prod [2];

  always_comb begin
    s1_lane_next[0].y = dates.data.start_year;
    s1_lane_next[0].m = dates.data.start_month;
    s1_lane_next[0].d = dates.data.start_day;
    s1_lane_next[1].y = dates.data.end_year;
    s1_lane_next[1].m = dates.data.end_month;
    s1_lane_next[1].d = dates.data.end_day;
    for (int i = 0; i < 2; i++) begin
      s1_prod[i] = PROD_W'(s1_lane_next[i].y) * PROD_W'(RECIP_100);
      s1_lane_next[i].q = s1_prod[i][RECIP_SHIFT +: QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_lane <= s1_lane_next;
      s1_inc  <= dates.data.include_end;
    end
  end

  // --------------------------------- stage 2: leap year, checks, day of year
  s2_lane_t          s2_lane [2];
  s2_lane_t          s2_lane_next [2];
  logic              s2_inc;
  logic [YEAR_W:0]   s2_hund [2];
  logic [REM_W-1:0]  s2_rem [2];
  logic              s2_leap [2];
  logic [DAY_W-1:0]  s2_mlen [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s2_hund[i] = (YEAR_W+1)'(s1_lane[i].q) * (YEAR_W+1)'(CENTURY);
      s2_rem[i]  = REM_W'({1'b0, s1_lane[i].y} - s2_hund[i]);
      // a year divisible by 100 is leap only when y / 100 divides by 4
      s2_leap[i] = (s1_lane[i].y[1:0] == 2'b00) &&
                   ((s2_rem[i] != '0) || (s1_lane[i].q[1:0] == 2'b00));
      s2_mlen[i] = month_len(s1_lane[i].m, s2_leap[i]);
      s2_lane_next[i].p  = s1_lane[i].y - YEAR_W'(1);
      // (y-1)/100 drops by one only when y is a whole century
      s2_lane_next[i].pq = (s2_rem[i] == '0) ? (s1_lane[i].q - QUOT_W'(1))
                                             : s1_lane[i].q;
      s2_lane_next[i].yday = days_before(s1_lane[i].m)
                           + YDAY_W'(s2_leap[i] && (s1_lane[i].m > FEBRUARY))
                           + YDAY_W'(s1_lane[i].d) - YDAY_W'(1);
      s2_lane_next[i].ok = (s1_lane[i].y != '0) &&
                           ({(CMP_W-YEAR_W)'(0), s1_lane[i].y} <= MaxYear) &&
                           (s1_lane[i].m != '0) && (s1_lane[i].m <= DECEMBER) &&
                           (s1_lane[i].d != '0) && (s1_lane[i].d <= s2_mlen[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_lane <= s2_lane_next;
      s2_inc  <= s1_inc;
    end
  end

  // ------------------------------------------- stage 3: serial day numbers
  logic [DNUM_W-1:0] s3_dnum [2];
  logic [DNUM_W-1:0] s3_dnum_next [2];
  logic              s3_err;
  logic              s3_inc;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s3_dnum_next[i] = DNUM_W'(s2_lane[i].p) * DAYS_PER_YEAR
                      + DNUM_W'(s2_lane[i].p >> 2)
                      - DNUM_W'(s2_lane[i].pq)
                      + DNUM_W'(s2_lane[i].pq >> 2)
                      + DNUM_W'(s2_lane[i].yday);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_dnum <= s3_dnum_next;
      s3_err  <= !(s2_lane[0].ok && s2_lane[1].ok);
      s3_inc  <= s2_inc;
    end
  end

  // ------------------------------- stage 4: difference, clamp, output register
  logic [DNUM_W:0]   s4_diff;
  logic [DNUM_W:0]   s4_sum;
  dd_out_t           s4_out;
  dd_out_t           s4_out_next;

  always_comb begin
    s4_diff = {1'b0, s3_dnum[1]} - {1'b0, s3_dnum[0]};
    if (s4_diff[DNUM_W]) begin
      s4_diff = '0;   // start not before end
    end
    s4_sum = s4_diff + (DNUM_W+1)'(s3_inc);
    s4_out_next.date_error = s3_err;
    if (s3_err) begin
      s4_out_next.day_count = '0;
    end else if (s4_sum > (DNUM_W+1)'(COUNT_MAX)) begin
      s4_out_next.day_count = COUNT_MAX;
    end else begin
      s4_out_next.day_count = s4_sum[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_out <= s4_out_next;
    end
  end

  assign days.valid = s4_valid;
  assign days.data  = s4_out;

  // ------------------------------------------------------------- assertions
  `DD_ASSERT_NOW(a_err_zero, s4_valid && s4_out.date_error, s4_out.day_count == '0, "error beat with nonzero count")
  `DD_ASSERT_NEXT(a_s3_moves, s3_valid && rdy4, s4_valid, "beat lost leaving stage 3")
  `DD_ASSERT_NOW(a_full_stall, !rdy1, s1_valid && s2_valid && s3_valid && s4_valid && !days.ready, "input stalled with a bubble in the pipe")

endmodule

`default_nettype wire
